>>> rtl/core/upd_pkg.sv
// Shared types, character codes and digit map for the URL percent decoder.
`default_nettype none

package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] LetterTop = 8'd25;
  localparam logic [7:0] LetterOfs = 8'd10;

  typedef enum logic [2:0] {
    PhIdle   = 3'b001,
    PhFirst  = 3'b010,
    PhSecond = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
  } result_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] high_nibble;
  } dec_state_t;

  // Lenient digit map: letters give 10..35, anything else wraps from '0'.
  function automatic logic [7:0] digit_value(input logic [7:0] b);
    logic [7:0] lower_ofs;
    logic [7:0] upper_ofs;
    lower_ofs = b - ChLowerA;
    upper_ofs = b - ChUpperA;
    if (b >= ChLowerA && lower_ofs <= LetterTop) begin
      digit_value = lower_ofs + LetterOfs;
    end else if (b >= ChUpperA && upper_ofs <= LetterTop) begin
      digit_value = upper_ofs + LetterOfs;
    end else begin
      digit_value = b - ChZero;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/upd_if.sv
// Valid/ready stream interfaces for the encoded and decoded byte channels.
`default_nettype none

interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  modport source (output valid, output out_byte, output out_last, output out_error,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_error,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/upd_decode.sv
// Per-byte decode logic: escape phase tracking and result formation.
`default_nettype none

module upd_decode (
  input  upd_pkg::item_t      item_i,
  input  upd_pkg::dec_state_t state_i,
  output upd_pkg::dec_state_t state_o,
  output logic                emit_o,
  output upd_pkg::result_t    result_o
);
  import upd_pkg::*;

  logic [7:0] digit;
  logic [7:0] combined;

  assign digit    = digit_value(item_i.in_byte);
  assign combined = {state_i.high_nibble, 4'b0000} + digit;

  always_comb begin
    state_o            = '{phase: PhIdle, high_nibble: 4'b0000};
    emit_o             = 1'b0;
    result_o.out_byte  = 8'h00;
    result_o.out_last  = item_i.in_last;
    result_o.out_error = 1'b0;
    case (state_i.phase)
      PhFirst: begin
        if (item_i.in_last) begin
          // string ended inside an escape: report and return to idle
          emit_o             = 1'b1;
          result_o.out_error = 1'b1;
        end else begin
          state_o.phase       = PhSecond;
          state_o.high_nibble = digit[3:0];
        end
      end
      PhSecond: begin
        emit_o            = 1'b1;
        result_o.out_byte = combined;
      end
      default: begin
        if (item_i.in_byte == ChPercent) begin
          if (item_i.in_last) begin
            emit_o             = 1'b1;
            result_o.out_error = 1'b1;
          end else begin
            state_o.phase = PhFirst;
          end
        end else begin
          emit_o            = 1'b1;
          result_o.out_byte = (item_i.in_byte == ChPlus) ? ChSpace : item_i.in_byte;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/url_percent_decoder.sv
// URL percent decoder: input register, decode logic and result register.
//
// Requests arrive on in_i, one encoded byte each, with in_last on the final
// byte of a string. Decoded bytes leave on out_o. A plain byte passes, '+'
// becomes a space, and '%' with the two following bytes yields one byte built
// from two lenient hex digits. The '%' and the first digit give no result; a
// string that ends on either of them gives one result with out_error set.
//
// A result passes through the input register, then the result register.
// Throughput: one request per cycle while out_o does not stall, set by the
// single decode stage between the two registers.
//
// Reset clears both valid flags and returns the escape state to idle.
// When out_o stalls, the result register holds; the input register still
// takes bytes that give no result, and in_i.ready drops only once the input
// register holds a byte that needs the occupied result register.
`default_nettype none

module url_percent_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  upd_in_if.sink     in_i,
  upd_out_if.source  out_o
);
  import upd_pkg::*;

  logic       s1_valid_q;
  item_t      s1_item_q;
  dec_state_t state_q;
  dec_state_t state_d;
  logic       emit;
  result_t    result_d;
  result_t    result_q;
  logic       out_valid_q;
  logic       s1_fire;

  upd_decode u_decode (
    .item_i   (s1_item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result_d)
  );

  // advance the held byte unless it needs a result slot that is still full
  assign s1_fire    = s1_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PhIdle, high_nibble: 4'b0000};
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_fire) begin
        state_q <= state_d;
      end
      if (s1_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q.in_byte <= in_i.in_byte;
      s1_item_q.in_last <= in_i.in_last;
    end
    if (s1_fire && emit) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = result_q.out_byte;
  assign out_o.out_last  = result_q.out_last;
  assign out_o.out_error = result_q.out_error;

endmodule

`default_nettype wire
